### hdl/mcem_pkg.sv
// Shared types and constants for the metronome click envelope mixer.
// No dependencies; imported by every module of the block.
package mcem_pkg;

   localparam int unsigned LEN_W    = 16;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned ENV_W    = 16;
   localparam int unsigned SAMPLE_W = 24;
   localparam int unsigned LEVEL_W  = 23;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned VOICE_COUNT_DEF = 4;
   localparam int unsigned TABLE_DEPTH_DEF = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCENT_GAIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_GAIN    = 2'd2;

   localparam logic [LEN_W-1:0]  CLICK_LENGTH_RST = 16'd480;
   localparam logic [GAIN_W-1:0] ACCENT_GAIN_RST  = 16'd32767;
   localparam logic [GAIN_W-1:0] BEAT_GAIN_RST    = 16'd16384;

   // one voice entry of the state memory
   typedef struct packed {
      logic [LEN_W-1:0] pos;
      logic             accent;
      logic             active;
   } voice_type;

   // divider request: quotient = num * TABLE_DEPTH / den
   typedef struct packed {
      logic             start;
      logic [LEN_W:0]   num;
      logic [LEN_W:0]   den;
   } div_req_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_EVAL = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_ACC  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

endpackage

### hdl/mcem_voice_mem.sv
// Voice state memory: one entry per voice, synchronous registered read.
// Per-entry valid bits make unwritten entries read as idle. Uses mcem_pkg.
module mcem_voice_mem import mcem_pkg::*; #(
   parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
   parameter int unsigned VW = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [VW-1:0]   rd_addr,
   output voice_type       rd_data,
   input  logic            wr_en,
   input  logic [VW-1:0]   wr_addr,
   input  voice_type       wr_data
);

   voice_type mem [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] valid_ff;
   logic [VOICE_COUNT-1:0] valid_in;
   voice_type rd_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_ff;

endmodule

### hdl/mcem_divider.sv
// Restoring divider, one quotient bit per cycle, for the envelope table index.
// Computes num * TABLE_DEPTH / den where the quotient is below TABLE_DEPTH. Uses mcem_pkg.
module mcem_divider import mcem_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned QW = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  div_req_type    req,
   output logic           done,
   output logic [QW-1:0]  quot
);

   localparam int unsigned DVD_W = LEN_W + 1 + QW;
   localparam int unsigned DSH_W = LEN_W + QW;
   localparam int unsigned CW = $clog2(QW);

   logic [DVD_W-1:0] rem_ff, rem_in;
   logic [DSH_W-1:0] dsh_ff, dsh_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] dvd;
   logic             fits;

   assign dvd  = DVD_W'(req.num) * DVD_W'(TABLE_DEPTH);
   assign fits = rem_ff >= DVD_W'(dsh_ff);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = dvd;
         dsh_in  = DSH_W'(req.den) << (QW - 1);
         q_in    = '0;
         cnt_in  = CW'(QW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - DVD_W'(dsh_ff);
         end
         q_in   = {q_ff[QW-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

### hdl/mcem_env_rom.sv
// Attack (raised cosine) and decay (exponential) envelope tables, Q1.15.
// Contents are built at elaboration from fixed-point series; registered read. Uses mcem_pkg.
module mcem_env_rom import mcem_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int unsigned QW = 8
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic              rd_decay,
   input  logic [QW-1:0]     rd_idx,
   output logic [ENV_W-1:0]  rd_data
);

   localparam longint Q30    = 64'sd1073741824;
   localparam longint PI_Q30 = 64'sd3373259426;

   // truncating signed division by shift and subtract, elaboration only
   function automatic longint cdiv(input longint a, input longint b);
      longint ua, ub, q;
      logic   neg;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      q   = 0;
      for (int i = 62; i >= 0; i--) begin
         if ((ua >>> i) >= ub) begin
            ua = ua - (ub <<< i);
            q  = q | (64'sd1 <<< i);
         end
      end
      return neg ? -q : q;
   endfunction

   function automatic logic [ENV_W-1:0] to_q15(input longint v);
      longint c;
      c = v;
      if (c < 0) c = 0;
      if (c > Q30) c = Q30;
      c = (c + 64'sd16384) >>> 15;
      return ENV_W'(c);
   endfunction

   // sin^2(pi*k/(2*D)) via Taylor series of sin
   function automatic logic [ENV_W-1:0] att_val(input int unsigned k);
      longint x, term, acc, n;
      x = cdiv(PI_Q30 * longint'(k), longint'(2 * TABLE_DEPTH));
      term = x;
      acc = x;
      for (n = 1; n <= 10; n++) begin
         term = term * x / Q30;
         term = term * x / Q30;
         term = cdiv(term, (2 * n) * (2 * n + 1));
         term = -term;
         acc = acc + term;
      end
      if (acc < 0) acc = 0;
      if (acc > Q30) acc = Q30;
      return to_q15(acc * acc / Q30);
   endfunction

   // exp(-6*k/D) as (exp(-6*k/(8*D)))^8
   function automatic logic [ENV_W-1:0] dec_val(input int unsigned k);
      longint z, term, acc, n, s;
      z = cdiv(6 * Q30 * longint'(k), longint'(TABLE_DEPTH)) / 8;
      term = Q30;
      acc = Q30;
      for (n = 1; n <= 16; n++) begin
         term = term * z / Q30;
         term = cdiv(term, n);
         term = -term;
         acc = acc + term;
      end
      if (acc < 0) acc = 0;
      if (acc > Q30) acc = Q30;
      for (s = 0; s < 3; s++) begin
         acc = acc * acc / Q30;
      end
      return to_q15(acc);
   endfunction

   logic [ENV_W-1:0] att_rom [TABLE_DEPTH];
   logic [ENV_W-1:0] dec_rom [TABLE_DEPTH];
   logic [ENV_W-1:0] rd_ff;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
      localparam logic [ENV_W-1:0] ATT = att_val(k);
      localparam logic [ENV_W-1:0] DEC = dec_val(k);
      assign att_rom[k] = ATT;
      assign dec_rom[k] = DEC;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= rd_decay ? dec_rom[rd_idx] : att_rom[rd_idx];
      end
   end

   assign rd_data = rd_ff;

endmodule

### hdl/metronome_click_envelope_mixer_top.sv
// Metronome click envelope mixer, top level: sequencer, gain multiply and mix.
// Uses mcem_pkg, mcem_voice_mem, mcem_divider and mcem_env_rom.
//
// Usage: one transaction on the req_ channel carries an audio sample, a beat
// trigger and an accent flag; one transaction on the rsp_ channel returns the
// sample with all active clicks mixed in, the click level alone and a flag
// that tells whether the trigger took a voice that was still sounding.
// csr_ writes set click length, accent gain and beat gain; write them only
// while no transaction is in flight.
// Timing: voices are handled one after another from the voice memory. An
// idle voice passes through the read and evaluate states; a sounding voice
// also passes through the divide, multiply and accumulate states, where the
// bit-serial divider forms the table index. A new sample is taken only
// after the last one has been worked through all voices.
// req_stall is high while an item is worked.
// Reset: all voices idle, registers at their defaults, no result pending.
// When rsp_stall holds a result, the block can still take the next sample and
// work it; it waits at the end until the output register is free.
module metronome_click_envelope_mixer_top import mcem_pkg::*; #(
   parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_beat_trigger,
   input  logic                        req_is_accent,
   input  logic signed [SAMPLE_W-1:0]  req_in_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_out_sample,
   output logic [LEVEL_W-1:0]          rsp_click_level,
   output logic                        rsp_voice_stolen,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int unsigned QW = $clog2(TABLE_DEPTH);
   localparam int unsigned SUM_W = SAMPLE_W + VW;
   localparam int unsigned PROD_W = GAIN_W + ENV_W;
   localparam logic [VW-1:0] LAST_VOICE = VW'(VOICE_COUNT - 1);
   localparam logic [SUM_W-1:0] LEVEL_MAX = SUM_W'((1 << LEVEL_W) - 1);

   state_type state_ff, state_in;
   logic [VW-1:0] vidx_ff, vidx_in;
   logic [VW-1:0] oldest_ff, oldest_in;
   logic trig_ff, trig_in, acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic stolen_ff, stolen_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic decay_ff, decay_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   logic [LEN_W-1:0] click_length_ff, accent_gain_ff, plain_gain_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   logic [LEVEL_W-1:0] click_level_ff;
   logic stolen_out_ff;

   voice_type rd_data, wr_data, cur;
   logic mem_rd_en, mem_wr_en;
   div_req_type div_req;
   logic div_done;
   logic [QW-1:0] div_quot;
   logic rom_rd_en;
   logic [ENV_W-1:0] env;

   logic [LEN_W-1:0] len, attack;
   logic [LEN_W:0] pos_nx;
   logic req_take, rsp_load;
   logic signed [SUM_W:0] total;
   logic signed [SAMPLE_W-1:0] total_sat;
   logic [LEVEL_W-1:0] level_sat;

   mcem_voice_mem #(.VOICE_COUNT(VOICE_COUNT), .VW(VW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (vidx_ff),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (vidx_ff),
      .wr_data (wr_data)
   );

   mcem_divider #(.TABLE_DEPTH(TABLE_DEPTH), .QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   mcem_env_rom #(.TABLE_DEPTH(TABLE_DEPTH), .QW(QW)) u_rom (
      .clock    (clock),
      .rd_en    (rom_rd_en),
      .rd_decay (decay_ff),
      .rd_idx   (div_quot),
      .rd_data  (env)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         click_length_ff <= CLICK_LENGTH_RST;
         accent_gain_ff  <= ACCENT_GAIN_RST;
         plain_gain_ff   <= BEAT_GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CLICK_LENGTH: click_length_ff <= csr_wr_data;
            CSR_ACCENT_GAIN:  accent_gain_ff  <= csr_wr_data;
            CSR_BEAT_GAIN:    plain_gain_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // zero length behaves as one; attack is a quarter, at least one
   assign len    = (click_length_ff == '0) ? LEN_W'(1) : click_length_ff;
   assign attack = ((len >> 2) == '0) ? LEN_W'(1) : (len >> 2);

   assign req_take = (state_ff == ST_IDLE) && req_valid;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign total = $signed({{(SUM_W + 1 - SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff})
                + $signed({1'b0, sum_ff});

   always_comb begin
      if (total > $signed((SUM_W + 1)'((1 << (SAMPLE_W - 1)) - 1))) begin
         total_sat = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      end else if (total < -$signed((SUM_W + 1)'(1 << (SAMPLE_W - 1)))) begin
         total_sat = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      end else begin
         total_sat = total[SAMPLE_W-1:0];
      end
      level_sat = (sum_ff > LEVEL_MAX) ? {LEVEL_W{1'b1}} : sum_ff[LEVEL_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      vidx_in   = vidx_ff;
      oldest_in = oldest_ff;
      trig_in   = trig_ff;
      acc_in    = acc_ff;
      sample_in = sample_ff;
      stolen_in = stolen_ff;
      sum_in    = sum_ff;
      decay_in  = decay_ff;
      gain_in   = gain_ff;
      prod_in   = prod_ff;
      mem_rd_en = 1'b0;
      mem_wr_en = 1'b0;
      rom_rd_en = 1'b0;
      div_req   = '0;
      cur       = rd_data;
      wr_data   = rd_data;
      pos_nx    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               trig_in   = req_beat_trigger;
               acc_in    = req_is_accent;
               sample_in = req_in_sample;
               stolen_in = 1'b0;
               sum_in    = '0;
               vidx_in   = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            // triggered voice restarts here and still sounds this sample unless len is one
            if (trig_ff && (vidx_ff == oldest_ff)) begin
               stolen_in  = rd_data.active;
               cur.active = 1'b1;
               cur.accent = acc_ff;
               cur.pos    = '0;
            end
            pos_nx = {1'b0, cur.pos} + 1'b1;
            wr_data = cur;
            gain_in = cur.accent ? accent_gain_ff : plain_gain_ff;
            decay_in = cur.pos >= attack;
            if (cur.pos < attack) begin
               div_req.num = pos_nx;
               div_req.den = {1'b0, attack} + 1'b1;
            end else begin
               div_req.num = {1'b0, cur.pos - attack};
               div_req.den = {1'b0, len - attack};
            end
            if (!cur.active) begin
               mem_wr_en = trig_ff && (vidx_ff == oldest_ff);
            end else if (cur.pos >= len) begin
               wr_data.active = 1'b0;
               mem_wr_en = 1'b1;
            end else begin
               wr_data.pos    = pos_nx[LEN_W-1:0];
               wr_data.active = pos_nx < {1'b0, len};
               mem_wr_en = 1'b1;
            end
            if (cur.active && (cur.pos < len) && (pos_nx < {1'b0, len})) begin
               div_req.start = 1'b1;
               state_in = ST_DIV;
            end else if (vidx_ff == LAST_VOICE) begin
               state_in = ST_DONE;
            end else begin
               vidx_in  = vidx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rom_rd_en = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = gain_ff * env;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // Q2.30 product rounded half up to 24-bit full scale
            sum_in = sum_ff + SUM_W'((prod_ff + PROD_W'(64)) >> 7);
            if (vidx_ff == LAST_VOICE) begin
               state_in = ST_DONE;
            end else begin
               vidx_in  = vidx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               if (trig_ff) begin
                  oldest_in = (oldest_ff == LAST_VOICE) ? '0 : oldest_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vidx_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vidx_ff      <= vidx_in;
         oldest_ff    <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trig_ff   <= trig_in;
      acc_ff    <= acc_in;
      sample_ff <= sample_in;
      stolen_ff <= stolen_in;
      sum_ff    <= sum_in;
      decay_ff  <= decay_in;
      gain_ff   <= gain_in;
      prod_ff   <= prod_in;
      if (rsp_load) begin
         out_sample_ff  <= total_sat;
         click_level_ff <= level_sat;
         stolen_out_ff  <= stolen_ff;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = out_sample_ff;
   assign rsp_click_level  = click_level_ff;
   assign rsp_voice_stolen = stolen_out_ff;

   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= LAST_VOICE)
      else $error("oldest voice pointer out of range");

   a_vidx_range: assert property (@(posedge clock) disable iff (reset)
      vidx_ff <= LAST_VOICE)
      else $error("voice index out of range");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_take_reads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_READ) && (vidx_ff == '0))
      else $error("accepted transaction did not start at voice zero");

   a_load_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result load did not present a result");

endmodule
